FILE: hdl/jtgs_pkg.sv
`timescale 1ns / 1ps

package jtgs_pkg;

    // default table geometry
    localparam int DOCS_DEF     = 1024;
    localparam int VOCAB_DEF    = 4096;
    localparam int TOPICS_DEF   = 16;
    localparam int CLUSTERS_DEF = 8;

    // widest topic walk supported by the weight store
    localparam int MAX_K = 16;

    // configuration register indexes
    localparam logic [3:0] CFG_ALPHA_FIRST   = 4'd0;
    localparam logic [3:0] CFG_BETA_FIRST    = 4'd1;
    localparam logic [3:0] CFG_ALPHA_SECOND  = 4'd2;
    localparam logic [3:0] CFG_BETA_SECOND   = 4'd3;
    localparam logic [3:0] CFG_VOCAB_FIRST   = 4'd4;
    localparam logic [3:0] CFG_VOCAB_SECOND  = 4'd5;
    localparam logic [3:0] CFG_TOPICS_FIRST  = 4'd6;
    localparam logic [3:0] CFG_TOPICS_SECOND = 4'd7;

    // configuration reset values
    localparam logic [15:0] PRIOR_RST  = 16'd256;
    localparam logic [12:0] VOCAB_RST  = 13'd4096;
    localparam logic [4:0]  TOPICS_RST = 5'd16;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_DEC_RD,
        S_DEC_WR,
        S_W_RD,
        S_W_LD,
        S_W_MUL,
        S_W_CHK,
        S_W_DIV,
        S_W_ACC,
        S_THR_LO,
        S_THR_HI,
        S_SRCH,
        S_INC_RD,
        S_INC_WR,
        S_DONE
    } t_state;

endpackage

FILE: hdl/joint_topic_gibbs_sampler_unit.sv
`timescale 1ns / 1ps

// Collapsed Gibbs topic sampler for two token kinds.
// Input channel (i_valid / o_ready) takes one token word: op, doc, word, kind,
// cluster, old topic and a 0.32 uniform draw. Output channel (o_valid / i_ready)
// returns one word per token: new topic and the count fault flag.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the priors,
// vocabulary sizes and topics in use; write only while the block is idle.
// One token is worked at a time. Index reduction subtracts DOCS, VOCAB or CLUSTERS
// from out-of-range indexes in repeated rounds until every index is in range.
// A resample, for each topic in use, reads three count tables, runs a
// four-partial-product multiply and a 1-bit-per-cycle 32-step divider;
// a saturated weight skips the divider.
// After reset every count table is swept to zero, one entry per cycle up to
// the depth of the largest table; no token is taken meanwhile.
// A finished result sits in an output register; the next token is accepted
// while it waits, and that token holds at its end until the register frees.
module joint_topic_gibbs_sampler_unit #(
    parameter int DOCS     = jtgs_pkg::DOCS_DEF,
    parameter int VOCAB    = jtgs_pkg::VOCAB_DEF,
    parameter int TOPICS   = jtgs_pkg::TOPICS_DEF,
    parameter int CLUSTERS = jtgs_pkg::CLUSTERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [9:0]  i_doc_id,
    input  logic [11:0] i_word_id,
    input  logic        i_token_kind,
    input  logic [2:0]  i_doc_cluster,
    input  logic [3:0]  i_old_topic,
    input  logic [31:0] i_uniform_draw,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_new_topic,
    output logic        o_count_fault,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import jtgs_pkg::*;

    localparam int DOC_N  = 2 * DOCS * TOPICS;
    localparam int WRD_N  = 2 * VOCAB * TOPICS;
    localparam int CLU_N  = 2 * CLUSTERS * TOPICS;
    localparam int TOT_N  = 2 * TOPICS;
    localparam int CLR_N  = (DOC_N > WRD_N) ? ((DOC_N > CLU_N) ? DOC_N : CLU_N)
                                            : ((WRD_N > CLU_N) ? WRD_N : CLU_N);
    localparam int DOC_AW = $clog2(DOC_N);
    localparam int WRD_AW = $clog2(WRD_N);
    localparam int CLU_AW = $clog2(CLU_N);
    localparam int TOT_AW = $clog2(TOT_N);
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int LIM_K  = (TOPICS < MAX_K) ? TOPICS : MAX_K;

    // configuration
    logic [15:0] r_alpha1, r_beta1, r_alpha2, r_beta2;
    logic [12:0] r_vocab1, r_vocab2;
    logic [4:0]  r_topics1, r_topics2;

    // token fields
    logic        r_op, r_kind;
    logic [9:0]  r_doc;
    logic [11:0] r_word;
    logic [2:0]  r_clu;
    logic [3:0]  r_top;
    logic [31:0] r_u;

    // sequencer
    t_state      r_state, n_state;
    logic [CLR_W-1:0] r_clr;
    logic [3:0]  r_t, r_pick;
    logic        r_fault;

    // weight datapath
    logic [40:0] r_a, r_b, r_d;
    logic [2:0]  r_ms;
    logic [63:0] r_pp;
    logic [81:0] r_acc;
    logic [41:0] r_rem;
    logic [31:0] r_nlo, r_q;
    logic [4:0]  r_ds;
    logic [31:0] r_w [MAX_K];
    logic [35:0] r_sum, r_thr, r_run;

    // output register
    logic        r_ov, r_onew_fault;
    logic [3:0]  r_onew;

    // memories
    logic [31:0] m_doc [DOC_N];
    logic [31:0] m_wrd [WRD_N];
    logic [31:0] m_clu [CLU_N];
    logic [31:0] m_tot [TOT_N];
    logic [31:0] rd_doc, rd_wrd, rd_clu, rd_tot;
    logic        we_doc, we_wrd, we_clu, we_tot;
    logic [DOC_AW-1:0] a_doc;
    logic [WRD_AW-1:0] a_wrd;
    logic [CLU_AW-1:0] a_clu;
    logic [TOT_AW-1:0] a_tot;
    logic [31:0] wd_doc, wd_wrd, wd_clu, wd_tot;

    // per-kind selections
    logic [15:0] alpha, beta;
    logic [12:0] vocab;
    logic [28:0] vbeta;
    logic [4:0]  treg, k;
    logic [3:0]  top_sat, tsel;
    logic        doc_hi, wrd_hi, clu_hi, red_done, last_t, over, hit;
    logic [35:0] run_n;
    logic [41:0] rem_sh;
    logic        clr_last;

    function automatic logic [31:0] dec_clamp(input logic [31:0] v);
        return (v == 32'd0) ? 32'd0 : v - 32'd1;
    endfunction

    function automatic logic [31:0] inc_sat(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // kind-dependent parameters and topic clamp
    always_comb begin
        alpha = r_kind ? r_alpha2 : r_alpha1;
        beta  = r_kind ? r_beta2  : r_beta1;
        vocab = r_kind ? r_vocab2 : r_vocab1;
        vbeta = {16'd0, vocab} * {13'd0, beta};
        treg  = r_kind ? r_topics2 : r_topics1;
        if (treg == 5'd0) begin
            k = 5'd1;
        end else if (int'(treg) > LIM_K) begin
            k = 5'(LIM_K);
        end else begin
            k = treg;
        end
        top_sat = ({1'b0, r_top} >= k) ? 4'(k - 5'd1) : r_top;
    end

    // index range reduction and loop flags
    always_comb begin
        doc_hi   = int'(r_doc) >= DOCS;
        wrd_hi   = int'(r_word) >= VOCAB;
        clu_hi   = int'(r_clu) >= CLUSTERS;
        red_done = !doc_hi && !wrd_hi && !clu_hi;
        last_t   = ({1'b0, r_t} == (k - 5'd1));
        over     = r_acc[81:24] >= {17'd0, r_d};
        rem_sh   = {r_rem[40:0], r_nlo[31]};
        run_n    = r_run + {4'd0, r_w[r_t]};
        hit      = run_n > r_thr;
        clr_last = (r_clr == CLR_W'(CLR_N - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (clr_last) n_state = S_IDLE;
            S_IDLE:   if (i_valid) n_state = S_REDUCE;
            S_REDUCE: if (red_done) n_state = r_op ? S_DEC_RD : S_INC_RD;
            S_DEC_RD: n_state = S_DEC_WR;
            S_DEC_WR: n_state = S_W_RD;
            S_W_RD:   n_state = S_W_LD;
            S_W_LD:   n_state = S_W_MUL;
            S_W_MUL:  if (r_ms == 3'd4) n_state = S_W_CHK;
            S_W_CHK:  n_state = over ? S_W_ACC : S_W_DIV;
            S_W_DIV:  if (r_ds == 5'd31) n_state = S_W_ACC;
            S_W_ACC:  n_state = last_t ? S_THR_LO : S_W_RD;
            S_THR_LO: n_state = S_THR_HI;
            S_THR_HI: n_state = S_SRCH;
            S_SRCH:   if (hit || last_t) n_state = S_INC_RD;
            S_INC_RD: n_state = S_INC_WR;
            S_INC_WR: n_state = S_DONE;
            S_DONE:   if (!r_ov || i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
        case (r_state)
            S_DEC_RD, S_DEC_WR: tsel = r_top;
            S_INC_RD, S_INC_WR: tsel = r_pick;
            default:            tsel = r_t;
        endcase
        we_doc = 1'b0;
        we_wrd = 1'b0;
        we_clu = 1'b0;
        we_tot = 1'b0;
        wd_doc = 32'd0;
        wd_wrd = 32'd0;
        wd_clu = 32'd0;
        wd_tot = 32'd0;
        a_doc = DOC_AW'(int'(r_kind) * DOCS * TOPICS + int'(r_doc) * TOPICS + int'(tsel));
        a_wrd = WRD_AW'(int'(r_kind) * VOCAB * TOPICS + int'(r_word) * TOPICS + int'(tsel));
        a_clu = CLU_AW'(int'(r_kind) * CLUSTERS * TOPICS + int'(r_clu) * TOPICS
                        + int'(tsel));
        a_tot = TOT_AW'(int'(r_kind) * TOPICS + int'(tsel));
        case (r_state)
            S_CLEAR: begin
                a_doc  = r_clr[DOC_AW-1:0];
                a_wrd  = r_clr[WRD_AW-1:0];
                a_clu  = r_clr[CLU_AW-1:0];
                a_tot  = r_clr[TOT_AW-1:0];
                we_doc = int'(r_clr) < DOC_N;
                we_wrd = int'(r_clr) < WRD_N;
                we_clu = int'(r_clr) < CLU_N;
                we_tot = int'(r_clr) < TOT_N;
            end
            S_DEC_WR: begin
                {we_doc, we_wrd, we_clu, we_tot} = 4'b1111;
                wd_doc = dec_clamp(rd_doc);
                wd_wrd = dec_clamp(rd_wrd);
                wd_clu = dec_clamp(rd_clu);
                wd_tot = dec_clamp(rd_tot);
            end
            S_INC_WR: begin
                {we_doc, we_wrd, we_clu, we_tot} = 4'b1111;
                wd_doc = inc_sat(rd_doc);
                wd_wrd = inc_sat(rd_wrd);
                wd_clu = inc_sat(rd_clu);
                wd_tot = inc_sat(rd_tot);
            end
            default: begin
            end
        endcase
    end

    // count table memories
    always_ff @(posedge i_clk) begin
        if (we_doc) m_doc[a_doc] <= wd_doc;
        rd_doc <= m_doc[a_doc];
    end

    always_ff @(posedge i_clk) begin
        if (we_wrd) m_wrd[a_wrd] <= wd_wrd;
        rd_wrd <= m_wrd[a_wrd];
    end

    always_ff @(posedge i_clk) begin
        if (we_clu) m_clu[a_clu] <= wd_clu;
        rd_clu <= m_clu[a_clu];
    end

    always_ff @(posedge i_clk) begin
        if (we_tot) m_tot[a_tot] <= wd_tot;
        rd_tot <= m_tot[a_tot];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha1  <= PRIOR_RST;
            r_beta1   <= PRIOR_RST;
            r_alpha2  <= PRIOR_RST;
            r_beta2   <= PRIOR_RST;
            r_vocab1  <= VOCAB_RST;
            r_vocab2  <= VOCAB_RST;
            r_topics1 <= TOPICS_RST;
            r_topics2 <= TOPICS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA_FIRST:   r_alpha1  <= i_cfg_data;
                CFG_BETA_FIRST:    r_beta1   <= i_cfg_data;
                CFG_ALPHA_SECOND:  r_alpha2  <= i_cfg_data;
                CFG_BETA_SECOND:   r_beta2   <= i_cfg_data;
                CFG_VOCAB_FIRST:   r_vocab1  <= i_cfg_data[12:0];
                CFG_VOCAB_SECOND:  r_vocab2  <= i_cfg_data[12:0];
                CFG_TOPICS_FIRST:  r_topics1 <= i_cfg_data[4:0];
                CFG_TOPICS_SECOND: r_topics2 <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + CLR_W'(1);
            if (r_state == S_DONE && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // token datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= i_op;
                r_doc   <= i_doc_id;
                r_word  <= i_word_id;
                r_kind  <= i_token_kind;
                r_clu   <= i_doc_cluster;
                r_top   <= i_old_topic;
                r_u     <= i_uniform_draw;
                r_fault <= 1'b0;
            end
            S_REDUCE: begin
                if (doc_hi) r_doc <= r_doc - 10'(DOCS);
                if (wrd_hi) r_word <= r_word - 12'(VOCAB);
                if (clu_hi) r_clu <= r_clu - 3'(CLUSTERS);
                r_top  <= top_sat;
                r_pick <= top_sat;
            end
            S_DEC_WR: begin
                r_fault <= (rd_doc == 32'd0) || (rd_wrd == 32'd0) ||
                           (rd_clu == 32'd0) || (rd_tot == 32'd0);
                r_t     <= 4'd0;
                r_sum   <= 36'd0;
            end
            S_W_LD: begin
                r_a   <= {1'b0, rd_clu, 8'd0} + {25'd0, alpha};
                r_b   <= {1'b0, rd_wrd, 8'd0} + {25'd0, beta};
                r_d   <= {1'b0, rd_tot, 8'd0} + {12'd0, vbeta};
                r_acc <= 82'd0;
                r_ms  <= 3'd0;
            end
            S_W_MUL: begin
                // one partial product a step, registered in r_pp before it is added
                case (r_ms)
                    3'd0:    r_pp <= {32'd0, r_a[31:0]} * {32'd0, r_b[31:0]};
                    3'd1:    r_pp <= {23'd0, {9'd0, r_a[31:0]} * {32'd0, r_b[40:32]}};
                    3'd2:    r_pp <= {23'd0, {32'd0, r_a[40:32]} * {9'd0, r_b[31:0]}};
                    3'd3:    r_pp <= {46'd0, {9'd0, r_a[40:32]} * {9'd0, r_b[40:32]}};
                    default: r_pp <= 64'd0;
                endcase
                case (r_ms)
                    3'd1:       r_acc <= r_acc + {18'd0, r_pp};
                    3'd2, 3'd3: r_acc <= r_acc + ({18'd0, r_pp} << 32);
                    3'd4:       r_acc <= r_acc + ({18'd0, r_pp} << 64);
                    default: begin
                    end
                endcase
                r_ms <= r_ms + 3'd1;
            end
            S_W_CHK: begin
                // quotient of 2^32 or more, or zero denominator, saturates
                r_q   <= over ? 32'hFFFF_FFFF : 32'd0;
                r_rem <= r_acc[65:24];
                r_nlo <= {r_acc[23:0], 8'd0};
                r_ds  <= 5'd0;
            end
            S_W_DIV: begin
                if (rem_sh >= {1'b0, r_d}) begin
                    r_rem <= rem_sh - {1'b0, r_d};
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_nlo <= {r_nlo[30:0], 1'b0};
                r_ds  <= r_ds + 5'd1;
            end
            S_W_ACC: begin
                r_w[r_t] <= r_q;
                r_sum    <= r_sum + {4'd0, r_q};
                r_t      <= last_t ? 4'd0 : r_t + 4'd1;
            end
            S_THR_LO: begin
                r_pp <= {32'd0, r_sum[31:0]} * {32'd0, r_u};
            end
            S_THR_HI: begin
                r_thr <= ({32'd0, r_sum[35:32]} * {4'd0, r_u}) + {4'd0, r_pp[63:32]};
                r_run <= 36'd0;
            end
            S_SRCH: begin
                // the last topic in use is the fallback pick
                r_run <= run_n;
                if (hit || last_t) begin
                    r_pick <= r_t;
                end else begin
                    r_t <= r_t + 4'd1;
                end
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    r_onew       <= r_pick;
                    r_onew_fault <= r_fault;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_ov;
    assign o_new_topic   = r_onew;
    assign o_count_fault = r_onew_fault;

endmodule
